>>> rtl/core/bmpn_pkg.sv
package bmpn_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int DATA_W   = 8;
    localparam int GAIN_W   = 18;
    localparam int BIAS_W   = 16;
    localparam int VALUE_W  = 16;
    localparam int STATUS_W = 3;
    localparam int CH_W     = 2;
    localparam int IDX_W    = 10;
    localparam int TDATA_W  = 40;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 18'd257;
    localparam logic [BIAS_W-1:0] BIAS_RESET = 16'd0;

    localparam logic [STATUS_W-1:0] ST_PIXEL       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MAGIC       = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PLANES      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BPP         = 3'd3;
    localparam logic [STATUS_W-1:0] ST_COMPRESSION = 3'd4;
    localparam logic [STATUS_W-1:0] ST_DIMENSIONS  = 3'd5;
    localparam logic [STATUS_W-1:0] ST_OFFSET      = 3'd6;

    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_CH2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_CH0 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_CH1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_CH2 = 3'd5;

    localparam logic [CH_W-1:0] CH_LAST = 2'd2;

endpackage

>>> rtl/core/bmp24_pixel_normalizer.sv
// Channel  Dir  Beat payload
// s_*      in   tdata: data_byte; tuser: start_of_file
// m_*      out  tdata: channel, row, column, pixel_value; tuser: status; tlast: image_last
// cfg_*    in   cfg_index: register number; cfg_data: register value
//
// One byte a cycle while the m side takes beats: a beat is captured in the input register,
// then the header parser and the multiply/add/saturate unit load the result register.
// Reset clears the parser to the first header byte and loads the default gains and biases.
// A stalled m side holds the result register and back-pressures s through the input register.
module bmp24_pixel_normalizer
#(
    parameter int MAX_WIDTH  = bmpn_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = bmpn_pkg::MAX_HEIGHT_DEF
)
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bmpn_pkg::DATA_W-1:0]        s_tdata,   // [7:0] data_byte
    input  logic                               s_tuser,   // [0] start_of_file

    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bmpn_pkg::TDATA_W-1:0]       m_tdata,   // [1:0] channel, [11:2] row,
                                                          // [21:12] column, [37:22] pixel_value
    output logic [bmpn_pkg::STATUS_W-1:0]      m_tuser,   // [2:0] status
    output logic                               m_tlast,   // image_last

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bmpn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpn_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int ROW_W = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);

    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_SKIP   = 3'd1;
    localparam logic [2:0] PH_PIXEL  = 3'd2;
    localparam logic [2:0] PH_PAD    = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    localparam logic [31:0] POS_MAGIC  = 32'd1;
    localparam logic [31:0] POS_OFFSET = 32'd13;
    localparam logic [31:0] POS_WIDTH  = 32'd25 - 32'd4;
    localparam logic [31:0] POS_HEIGHT = 32'd25;
    localparam logic [31:0] POS_PLANES = 32'd27;
    localparam logic [31:0] POS_BPP    = 32'd29;
    localparam logic [31:0] POS_COMPR  = 32'd33;
    localparam logic [31:0] POS_HDREND = 32'd53;
    localparam logic [31:0] HDR_LEN    = 32'd54;

    localparam logic [15:0] MAGIC      = 16'h4d42;
    localparam logic [15:0] PLANES     = 16'd1;
    localparam logic [15:0] BPP        = 16'd24;

    logic                               in_valid_reg, in_valid_next;
    logic [bmpn_pkg::DATA_W-1:0]        in_data_reg, in_data_next;
    logic                               in_sof_reg, in_sof_next;

    logic [2:0]                         phase_reg, phase_next;
    logic [31:0]                        pos_reg, pos_next;
    logic [31:0]                        fa_reg, fa_next;
    logic [31:0]                        offset_reg, offset_next;
    logic [WID_W-1:0]                   width_reg, width_next;
    logic [HGT_W-1:0]                   height_reg, height_next;
    logic [ROW_W-1:0]                   row_reg, row_next;
    logic [COL_W-1:0]                   col_reg, col_next;
    logic [bmpn_pkg::CH_W-1:0]          ch_reg, ch_next;
    logic [1:0]                         pad_reg, pad_next;

    logic [bmpn_pkg::GAIN_W-1:0]        gain_reg [3];
    logic [bmpn_pkg::BIAS_W-1:0]        bias_reg [3];

    logic                               out_valid_reg, out_valid_next;
    logic [bmpn_pkg::STATUS_W-1:0]      out_status_reg, out_status_next;
    logic [bmpn_pkg::CH_W-1:0]          out_ch_reg, out_ch_next;
    logic [bmpn_pkg::IDX_W-1:0]         out_row_reg, out_row_next;
    logic [bmpn_pkg::IDX_W-1:0]         out_col_reg, out_col_next;
    logic [bmpn_pkg::VALUE_W-1:0]       out_value_reg, out_value_next;
    logic                               out_last_reg, out_last_next;

    logic                               s_accept;
    logic                               advance;
    logic [2:0]                         phase_cur;
    logic [31:0]                        pos_cur;
    logic [31:0]                        pos_inc;
    logic [31:0]                        fa_new;
    logic                               last_in_row;
    logic                               last_pix;
    logic [bmpn_pkg::GAIN_W-1:0]        gain_sel;
    logic [bmpn_pkg::BIAS_W-1:0]        bias_sel;
    logic signed [bmpn_pkg::VALUE_W-1:0] scaled;
    logic                               err_hit;
    logic [bmpn_pkg::STATUS_W-1:0]      err_code;
    logic                               enter_hit;

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_accept  = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign phase_cur   = in_sof_reg ? PH_HEADER : phase_reg;
    assign pos_cur     = in_sof_reg ? 32'd0 : pos_reg;
    assign pos_inc     = pos_cur + 32'd1;
    assign fa_new      = {in_data_reg, fa_reg[31:8]};
    assign last_in_row = (ch_reg == bmpn_pkg::CH_LAST)
                         && (32'(col_reg) + 32'd1 >= 32'(width_reg));
    assign last_pix    = last_in_row && (row_reg == '0);

    always_comb
    begin
        case (ch_reg)
            2'd1:
            begin
                gain_sel = gain_reg[1];
                bias_sel = bias_reg[1];
            end
            2'd2:
            begin
                gain_sel = gain_reg[2];
                bias_sel = bias_reg[2];
            end
            default:
            begin
                gain_sel = gain_reg[0];
                bias_sel = bias_reg[0];
            end
        endcase
    end

    bmpn_scale u_scale
    (
        .data_byte (in_data_reg),
        .gain      (gain_sel),
        .bias      ($signed(bias_sel)),
        .result    (scaled)
    );

    // header checks, each at the last byte of its field; the offset check at the last header byte
    always_comb
    begin
        err_hit     = 1'b0;
        err_code    = bmpn_pkg::ST_PIXEL;
        enter_hit   = 1'b0;
        case (pos_cur)
            POS_MAGIC:
            begin
                if (fa_new[31:16] != MAGIC)
                begin
                    err_hit  = 1'b1;
                    err_code = bmpn_pkg::ST_MAGIC;
                end
            end
            POS_WIDTH:
            begin
                if (fa_new == 32'd0 || fa_new > 32'(MAX_WIDTH))
                begin
                    err_hit  = 1'b1;
                    err_code = bmpn_pkg::ST_DIMENSIONS;
                end
            end
            POS_HEIGHT:
            begin
                if (fa_new == 32'd0 || fa_new > 32'(MAX_HEIGHT))
                begin
                    err_hit  = 1'b1;
                    err_code = bmpn_pkg::ST_DIMENSIONS;
                end
            end
            POS_PLANES:
            begin
                if (fa_new[31:16] != PLANES)
                begin
                    err_hit  = 1'b1;
                    err_code = bmpn_pkg::ST_PLANES;
                end
            end
            POS_BPP:
            begin
                if (fa_new[31:16] != BPP)
                begin
                    err_hit  = 1'b1;
                    err_code = bmpn_pkg::ST_BPP;
                end
            end
            POS_COMPR:
            begin
                if (fa_new != 32'd0)
                begin
                    err_hit  = 1'b1;
                    err_code = bmpn_pkg::ST_COMPRESSION;
                end
            end
            POS_HDREND:
            begin
                if (offset_reg < HDR_LEN)
                begin
                    err_hit  = 1'b1;
                    err_code = bmpn_pkg::ST_OFFSET;
                end
                else if (pos_inc >= offset_reg)
                begin
                    enter_hit = 1'b1;
                end
            end
            default:
            begin
                err_hit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        in_valid_next   = in_valid_reg;
        in_data_next    = in_data_reg;
        in_sof_next     = in_sof_reg;
        phase_next      = phase_reg;
        pos_next        = pos_reg;
        fa_next         = fa_reg;
        offset_next     = offset_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        row_next        = row_reg;
        col_next        = col_reg;
        ch_next         = ch_reg;
        pad_next        = pad_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_ch_next     = out_ch_reg;
        out_row_next    = out_row_reg;
        out_col_next    = out_col_reg;
        out_value_next  = out_value_reg;
        out_last_next   = out_last_reg;

        if (advance)
        begin
            in_valid_next = 1'b0;
        end
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            in_data_next  = s_tdata;
            in_sof_next   = s_tuser;
        end

        if (advance)
        begin
            phase_next = phase_cur;
            pos_next   = pos_cur;
            case (phase_cur)
                PH_HEADER:
                begin
                    fa_next  = fa_new;
                    pos_next = pos_inc;
                    if (pos_cur == POS_OFFSET)
                    begin
                        offset_next = fa_new;
                    end
                    if (pos_cur == POS_WIDTH)
                    begin
                        width_next = WID_W'(fa_new);
                    end
                    if (pos_cur == POS_HEIGHT)
                    begin
                        height_next = HGT_W'(fa_new);
                    end
                    if (err_hit)
                    begin
                        phase_next      = PH_DONE;
                        out_valid_next  = 1'b1;
                        out_status_next = err_code;
                        out_ch_next     = '0;
                        out_row_next    = '0;
                        out_col_next    = '0;
                        out_value_next  = '0;
                        out_last_next   = 1'b1;
                    end
                    else if (pos_cur == POS_HDREND)
                    begin
                        phase_next = enter_hit ? PH_PIXEL : PH_SKIP;
                        row_next   = ROW_W'(height_reg - HGT_W'(1));
                        col_next   = '0;
                        ch_next    = '0;
                    end
                end
                PH_SKIP:
                begin
                    pos_next = pos_inc;
                    if (pos_inc >= offset_reg)
                    begin
                        phase_next = PH_PIXEL;
                        row_next   = ROW_W'(height_reg - HGT_W'(1));
                        col_next   = '0;
                        ch_next    = '0;
                    end
                end
                PH_PIXEL:
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = bmpn_pkg::ST_PIXEL;
                    out_ch_next     = ch_reg;
                    out_row_next    = bmpn_pkg::IDX_W'(row_reg);
                    out_col_next    = bmpn_pkg::IDX_W'(col_reg);
                    out_value_next  = scaled;
                    out_last_next   = last_pix;
                    if (last_pix)
                    begin
                        phase_next = PH_DONE;
                    end
                    else if (ch_reg != bmpn_pkg::CH_LAST)
                    begin
                        ch_next = ch_reg + 2'd1;
                    end
                    else
                    begin
                        ch_next = '0;
                        if (!last_in_row)
                        begin
                            col_next = col_reg + COL_W'(1);
                        end
                        else
                        begin
                            col_next = '0;
                            row_next = row_reg - ROW_W'(1);
                            pad_next = 2'(width_reg);
                            if (2'(width_reg) != 2'd0)
                            begin
                                phase_next = PH_PAD;
                            end
                        end
                    end
                end
                PH_PAD:
                begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_reg == 2'd1)
                    begin
                        phase_next = PH_PIXEL;
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_HEADER;
            pos_reg       <= '0;
            fa_reg        <= '0;
            offset_reg    <= '0;
            width_reg     <= '0;
            height_reg    <= '0;
            row_reg       <= '0;
            col_reg       <= '0;
            ch_reg        <= '0;
            pad_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            fa_reg        <= fa_next;
            offset_reg    <= offset_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            ch_reg        <= ch_next;
            pad_reg       <= pad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_data_reg    <= in_data_next;
        in_sof_reg     <= in_sof_next;
        out_status_reg <= out_status_next;
        out_ch_reg     <= out_ch_next;
        out_row_reg    <= out_row_next;
        out_col_reg    <= out_col_next;
        out_value_reg  <= out_value_next;
        out_last_reg   <= out_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg[0] <= bmpn_pkg::GAIN_RESET;
            gain_reg[1] <= bmpn_pkg::GAIN_RESET;
            gain_reg[2] <= bmpn_pkg::GAIN_RESET;
            bias_reg[0] <= bmpn_pkg::BIAS_RESET;
            bias_reg[1] <= bmpn_pkg::BIAS_RESET;
            bias_reg[2] <= bmpn_pkg::BIAS_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bmpn_pkg::REG_GAIN_CH0: gain_reg[0] <= cfg_data;
                bmpn_pkg::REG_GAIN_CH1: gain_reg[1] <= cfg_data;
                bmpn_pkg::REG_GAIN_CH2: gain_reg[2] <= cfg_data;
                bmpn_pkg::REG_BIAS_CH0: bias_reg[0] <= cfg_data[bmpn_pkg::BIAS_W-1:0];
                bmpn_pkg::REG_BIAS_CH1: bias_reg[1] <= cfg_data[bmpn_pkg::BIAS_W-1:0];
                bmpn_pkg::REG_BIAS_CH2: bias_reg[2] <= cfg_data[bmpn_pkg::BIAS_W-1:0];
                default:
                begin
                    // drop writes to unknown registers
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {2'b00, out_value_reg, out_col_reg, out_row_reg, out_ch_reg};

endmodule

>>> rtl/core/bmpn_scale.sv
module bmpn_scale
(
    input  logic [bmpn_pkg::DATA_W-1:0]         data_byte,
    input  logic [bmpn_pkg::GAIN_W-1:0]         gain,
    input  logic signed [bmpn_pkg::BIAS_W-1:0]  bias,
    output logic signed [bmpn_pkg::VALUE_W-1:0] result
);

    localparam int PROD_W  = bmpn_pkg::DATA_W + bmpn_pkg::GAIN_W;
    localparam int SHIFT_W = PROD_W - 4;
    localparam int SUM_W   = SHIFT_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(32767);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(32768);

    logic [PROD_W-1:0]        product;
    logic [SHIFT_W-1:0]       scaled;
    logic signed [SUM_W-1:0]  sum;

    assign product = PROD_W'(data_byte) * PROD_W'(gain);
    assign scaled  = product[PROD_W-1:4];
    assign sum     = $signed({2'b00, scaled}) + SUM_W'(bias);

    always_comb
    begin
        if (sum > SAT_HI)
        begin
            result = 16'sd32767;
        end
        else if (sum < SAT_LO)
        begin
            result = -16'sd32768;
        end
        else
        begin
            result = sum[bmpn_pkg::VALUE_W-1:0];
        end
    end

endmodule

>>> rtl/core/bmpn_checker.sv
module bmpn_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [bmpn_pkg::TDATA_W-1:0]       m_tdata,
    input  logic [bmpn_pkg::STATUS_W-1:0]      m_tuser,
    input  logic                               m_tlast
);

    // hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("result beat changed while stalled");

    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != bmpn_pkg::ST_PIXEL |-> m_tlast && m_tdata == '0)
        else $error("error beat without last or with payload");

    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tuser <= bmpn_pkg::ST_OFFSET)
        else $error("status code out of range");

    a_channel: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == bmpn_pkg::ST_PIXEL |-> m_tdata[1:0] <= bmpn_pkg::CH_LAST)
        else $error("channel out of range");

    // the last beat of an image always carries the last component of a pixel in row 0
    a_last_ch: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tuser == bmpn_pkg::ST_PIXEL
            |-> m_tdata[1:0] == bmpn_pkg::CH_LAST && m_tdata[11:2] == '0)
        else $error("image end on a wrong component");

endmodule

bind bmp24_pixel_normalizer bmpn_checker u_bmpn_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/bmpn_beat_checker.sv
module bmpn_beat_checker
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [bmpn_pkg::DATA_W-1:0]        s_tdata,    // [7:0] data_byte
    input  logic                               s_tuser,    // [0] start_of_file

    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [bmpn_pkg::TDATA_W-1:0]       m_tdata,    // [1:0] channel, [11:2] row,
                                                           // [21:12] column, [37:22] pixel_value
    input  logic [bmpn_pkg::STATUS_W-1:0]      m_tuser,    // [2:0] status
    input  logic                               m_tlast,

    input  logic                               cfg_valid,
    input  logic                               cfg_ready,
    input  logic [bmpn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bmpn_pkg::CFG_DATA_W-1:0]    cfg_data,

    output int                                 bad_beats,
    output int                                 beats_due
);

    import bmpn_pkg::*;

    typedef enum logic [2:0]
    {
        PARSE_HEADER,
        PARSE_SKIP,
        PARSE_PIXEL,
        PARSE_PAD,
        PARSE_DONE
    } parse_phase_e;

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic [CH_W-1:0]     channel;
        logic [IDX_W-1:0]    row;
        logic [IDX_W-1:0]    column;
        logic [VALUE_W-1:0]  value;
        logic                last;
    } norm_beat_t;

    localparam logic [15:0] BMP_MAGIC  = 16'h4d42;
    localparam logic [15:0] BMP_BPP    = 16'd24;
    localparam logic [31:0] HEADER_END = 32'd54;

    logic [GAIN_W-1:0]        gain [3];
    logic signed [BIAS_W-1:0] bias [3];

    parse_phase_e phase = PARSE_HEADER;
    logic [31:0]  byte_pos = '0;
    logic [31:0]  field = '0;
    logic [31:0]  pix_offset = '0;
    logic [10:0]  img_w = '0;
    logic [10:0]  img_h = '0;
    logic [9:0]   row_q = '0;
    logic [9:0]   col_q = '0;
    logic [1:0]   chan_q = '0;
    logic [1:0]   pad_q = '0;

    norm_beat_t pixel_due [$];
    int         mismatches = 0;

    function automatic void rewind();
        phase      = PARSE_HEADER;
        byte_pos   = '0;
        field      = '0;
        pix_offset = '0;
        img_w      = '0;
        img_h      = '0;
        row_q      = '0;
        col_q      = '0;
        chan_q     = '0;
        pad_q      = '0;
    endfunction

    function automatic void start_pixels();
        phase  = PARSE_PIXEL;
        row_q  = 10'(img_h - 11'd1);
        col_q  = '0;
        chan_q = '0;
    endfunction

    function automatic logic parse_byte(input logic [7:0] b, input logic sof,
                                        output norm_beat_t r);
        logic [31:0]         at;
        logic [STATUS_W-1:0] err;
        logic                row_end;
        logic                img_end;
        int                  v;
        r   = '0;
        err = ST_PIXEL;
        if (sof)
            rewind();
        case (phase)
            PARSE_HEADER:
            begin
                at       = byte_pos;
                field    = {b, field[31:8]};
                byte_pos = at + 32'd1;
                if (at == 32'd1)
                begin
                    if (field[31:16] != BMP_MAGIC)
                        err = ST_MAGIC;
                end
                else if (at == 32'd13)
                    pix_offset = field;
                else if (at == 32'd21)
                begin
                    if (field < 32'd1 || field > 32'(MAX_WIDTH_DEF))
                        err = ST_DIMENSIONS;
                    else
                        img_w = field[10:0];
                end
                else if (at == 32'd25)
                begin
                    if (field < 32'd1 || field > 32'(MAX_HEIGHT_DEF))
                        err = ST_DIMENSIONS;
                    else
                        img_h = field[10:0];
                end
                else if (at == 32'd27)
                begin
                    if (field[31:16] != 16'd1)
                        err = ST_PLANES;
                end
                else if (at == 32'd29)
                begin
                    if (field[31:16] != BMP_BPP)
                        err = ST_BPP;
                end
                else if (at == 32'd33)
                begin
                    if (field != 32'd0)
                        err = ST_COMPRESSION;
                end
                else if (at == 32'd53)
                begin
                    if (pix_offset < HEADER_END)
                        err = ST_OFFSET;
                    else if (byte_pos >= pix_offset)
                        start_pixels();
                    else
                        phase = PARSE_SKIP;
                end
                if (err != ST_PIXEL)
                begin
                    r.status = err;
                    r.last   = 1'b1;
                    phase    = PARSE_DONE;
                    return 1'b1;
                end
                return 1'b0;
            end
            PARSE_SKIP:
            begin
                byte_pos = byte_pos + 32'd1;
                if (byte_pos >= pix_offset)
                    start_pixels();
                return 1'b0;
            end
            PARSE_PIXEL:
            begin
                row_end = (chan_q == CH_LAST) && (32'(col_q) + 32'd1 >= 32'(img_w));
                img_end = row_end && (row_q == '0);
                v = int'((32'(b) * 32'(gain[chan_q])) >> 4) + int'(bias[chan_q]);
                if (v > 32767)
                    v = 32767;
                else if (v < -32768)
                    v = -32768;
                r.status  = ST_PIXEL;
                r.channel = chan_q;
                r.row     = row_q;
                r.column  = col_q;
                r.value   = v[15:0];
                r.last    = img_end;
                if (img_end)
                    phase = PARSE_DONE;
                else if (chan_q != CH_LAST)
                    chan_q = chan_q + 2'd1;
                else
                begin
                    chan_q = '0;
                    if (!row_end)
                        col_q = col_q + 10'd1;
                    else
                    begin
                        col_q = '0;
                        row_q = row_q - 10'd1;
                        pad_q = img_w[1:0];
                        if (pad_q != '0)
                            phase = PARSE_PAD;
                    end
                end
                return 1'b1;
            end
            PARSE_PAD:
            begin
                pad_q = pad_q - 2'd1;
                if (pad_q == '0)
                    phase = PARSE_PIXEL;
                return 1'b0;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        norm_beat_t want;
        norm_beat_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                gain[k] = GAIN_RESET;
                bias[k] = BIAS_RESET;
            end
            rewind();
            pixel_due.delete();
            mismatches = 0;
            bad_beats <= 0;
            beats_due <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GAIN_CH0: gain[0] = cfg_data;
                    REG_GAIN_CH1: gain[1] = cfg_data;
                    REG_GAIN_CH2: gain[2] = cfg_data;
                    REG_BIAS_CH0: bias[0] = cfg_data[BIAS_W-1:0];
                    REG_BIAS_CH1: bias[1] = cfg_data[BIAS_W-1:0];
                    REG_BIAS_CH2: bias[2] = cfg_data[BIAS_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got.status  = m_tuser;
                got.channel = m_tdata[1:0];
                got.row     = m_tdata[11:2];
                got.column  = m_tdata[21:12];
                got.value   = m_tdata[37:22];
                got.last    = m_tlast;
                if (pixel_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected beat: status %0d ch %0d row %0d col %0d value %0d last %0b",
                                 got.status, got.channel, got.row, got.column,
                                 $signed(got.value), got.last);
                end
                else
                begin
                    want = pixel_due.pop_front();
                    if (got.status !== want.status || got.channel !== want.channel ||
                        got.row !== want.row || got.column !== want.column ||
                        got.value !== want.value || got.last !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("beat mismatch: expected status %0d ch %0d row %0d col %0d value %0d last %0b",
                                     want.status, want.channel, want.row, want.column,
                                     $signed(want.value), want.last);
                            $display("               got      status %0d ch %0d row %0d col %0d value %0d last %0b",
                                     got.status, got.channel, got.row, got.column,
                                     $signed(got.value), got.last);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (parse_byte(s_tdata, s_tuser, want))
                    pixel_due.push_back(want);
            end
            bad_beats <= mismatches;
            beats_due <= pixel_due.size();
        end
    end

endmodule

>>> tb/testbench.sv
module testbench;

    import bmpn_pkg::*;

    localparam int          QUIET_LIMIT = 2000;
    localparam logic [15:0] BMP_MAGIC   = 16'h4d42;

    logic                  clk;
    logic                  rst_n = 1'b0;

    logic                  s_tvalid = 1'b0;
    wire                   s_tready;
    logic [DATA_W-1:0]     s_tdata = '0;
    logic                  s_tuser = 1'b0;

    wire                   m_tvalid;
    logic                  m_tready = 1'b0;
    wire  [TDATA_W-1:0]    m_tdata;
    wire  [STATUS_W-1:0]   m_tuser;
    wire                   m_tlast;

    logic                  cfg_valid = 1'b0;
    wire                   cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int   bad_beats;
    int   beats_due;
    logic calm = 1'b0;
    int   quiet = 0;
    int   stall_left = 0;
    int   bytes_sent = 0;
    int   idle_pct = 20;
    logic [7:0] file_q [$];

    bmp24_pixel_normalizer u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bmpn_beat_checker u_check
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .bad_beats (bad_beats),
        .beats_due (beats_due)
    );

    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (rst_n && !calm && $urandom_range(0, 7) == 0)
        begin
            stall_left <= $urandom_range(0, 5);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                quiet <= 0;
            else if (quiet >= QUIET_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
            else
                quiet <= quiet + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic sof);
        if (!calm && $urandom_range(0, 99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // hold the stream until every pending beat is out and the pipeline is empty
    task automatic settle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (beats_due != 0)
            @(posedge clk);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic put_le(input logic [31:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_q.push_back(v[8*i +: 8]);
    endtask

    task automatic build_bmp(input logic [15:0] magic, input logic [31:0] off,
                             input logic [31:0] wd, input logic [31:0] ht,
                             input logic [15:0] planes, input logic [15:0] bpp,
                             input logic [31:0] comp);
        int row_bytes;
        file_q.delete();
        put_le(32'(magic), 2);
        put_le($urandom, 4);
        put_le($urandom, 4);
        put_le(off, 4);
        put_le(32'd40, 4);
        put_le(wd, 4);
        put_le(ht, 4);
        put_le(32'(planes), 2);
        put_le(32'(bpp), 2);
        put_le(comp, 4);
        for (int i = 0; i < 20; i++)
            file_q.push_back(8'($urandom));
        if (off >= 32'd54 && off <= 32'd80)
            for (int i = 54; i < int'(off); i++)
                file_q.push_back(8'($urandom));
        if (wd >= 32'd1 && wd <= 32'(MAX_WIDTH_DEF) && ht >= 32'd1 && ht <= 32'(MAX_HEIGHT_DEF))
        begin
            row_bytes = 3 * int'(wd) + int'(wd & 32'd3);
            for (int i = 0; i < row_bytes * int'(ht); i++)
                file_q.push_back(8'($urandom));
        end
        repeat ($urandom_range(0, 3))
            file_q.push_back(8'($urandom));
    endtask

    task automatic send_file(input int keep, input logic sof_first);
        if (keep == 0 || keep > file_q.size())
            keep = file_q.size();
        for (int i = 0; i < keep; i++)
            send_byte(file_q[i], sof_first && i == 0);
    endtask

    task automatic bmp_case(input logic [15:0] magic, input logic [31:0] off,
                            input logic [31:0] wd, input logic [31:0] ht,
                            input logic [15:0] planes, input logic [15:0] bpp,
                            input logic [31:0] comp, input logic sof, input int keep);
        build_bmp(magic, off, wd, ht, planes, bpp, comp);
        send_file(keep, sof);
    endtask

    task automatic random_file();
        logic [15:0] magic;
        logic [15:0] planes;
        logic [15:0] bpp;
        logic [31:0] wd;
        logic [31:0] ht;
        logic [31:0] off;
        logic [31:0] comp;
        int          kind;
        int          keep;
        magic  = BMP_MAGIC;
        planes = 16'd1;
        bpp    = 16'd24;
        comp   = '0;
        keep   = 0;
        idle_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
        wd  = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
        ht  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 12) : $urandom_range(1, 4);
        off = 32'd54 + (($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0);
        kind = $urandom_range(0, 19);
        case (kind)
            12: off = $urandom_range(200, 1000000);
            13:
            begin
                magic = $urandom_range(0, 1) ? (BMP_MAGIC ^ (16'h1 << $urandom_range(0, 15)))
                                             : 16'($urandom);
                if (magic == BMP_MAGIC)
                    magic[0] = 1'b1;
            end
            14:
            begin
                planes = $urandom_range(0, 1) ? 16'($urandom_range(0, 3)) : 16'($urandom);
                if (planes == 16'd1)
                    planes = 16'd0;
            end
            15:
            begin
                bpp = $urandom_range(0, 1) ? 16'(8 * $urandom_range(0, 4)) : 16'($urandom);
                if (bpp == 16'd24)
                    bpp = 16'd32;
            end
            16: comp = $urandom_range(0, 1) ? $urandom_range(1, 6) : ($urandom | 32'h1);
            17, 18:
            begin
                case ($urandom_range(0, 3))
                    0: wd = 32'd0;
                    1: wd = 32'(MAX_WIDTH_DEF) + 32'd1;
                    2: wd = $urandom_range(1025, 65536);
                    default: wd = $urandom | 32'h8000_0000;
                endcase
                if (kind == 18)
                begin
                    ht = wd;
                    wd = $urandom_range(1, 6);
                end
            end
            19: off = $urandom_range(0, 53);
            default: ;
        endcase
        build_bmp(magic, off, wd, ht, planes, bpp, comp);
        if (kind >= 12)
            keep = 54 + $urandom_range(0, 3);
        else if (kind == 11)
            keep = $urandom_range(1, file_q.size() - 1);
        if ($urandom_range(0, 15) == 0)
            settle();
        send_file(keep, $urandom_range(0, 19) != 0);
        if ($urandom_range(0, 9) == 0)
            repeat ($urandom_range(1, 8))
                send_byte(8'($urandom), $urandom_range(0, 3) == 0);
    endtask

    task automatic load_coeffs(input logic [GAIN_W-1:0] g0, input logic [GAIN_W-1:0] g1,
                               input logic [GAIN_W-1:0] g2, input logic [BIAS_W-1:0] b0,
                               input logic [BIAS_W-1:0] b1, input logic [BIAS_W-1:0] b2);
        logic [CFG_IDX_W-1:0]  idx [6];
        logic [CFG_DATA_W-1:0] val [6];
        idx[0] = REG_GAIN_CH0;
        idx[1] = REG_GAIN_CH1;
        idx[2] = REG_GAIN_CH2;
        idx[3] = REG_BIAS_CH0;
        idx[4] = REG_BIAS_CH1;
        idx[5] = REG_BIAS_CH2;
        val[0] = g0;
        val[1] = g1;
        val[2] = g2;
        val[3] = {2'($urandom), b0};
        val[4] = {2'($urandom), b1};
        val[5] = {2'($urandom), b2};
        settle();
        for (int k = 0; k < 6; k++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[k];
            cfg_data  <= val[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        int target;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;

        // first file straight after reset, no start flag
        bmp_case(BMP_MAGIC, 32'd54, 32'd1, 32'd1, 16'd1, 16'd24, 32'd0, 1'b0, 0);
        bmp_case(16'h4d43, 32'd54, 32'd1, 32'd1, 16'd1, 16'd24, 32'd0, 1'b1, 4);
        bmp_case(BMP_MAGIC, 32'd54, 32'd0, 32'd1, 16'd1, 16'd24, 32'd0, 1'b1, 24);
        bmp_case(BMP_MAGIC, 32'd54, 32'd1025, 32'd1, 16'd1, 16'd24, 32'd0, 1'b1, 24);
        bmp_case(BMP_MAGIC, 32'd54, 32'd1, 32'd0, 16'd1, 16'd24, 32'd0, 1'b1, 28);
        // top-down height
        bmp_case(BMP_MAGIC, 32'd54, 32'd2, 32'hFFFF_FFFF, 16'd1, 16'd24, 32'd0, 1'b1, 28);
        bmp_case(BMP_MAGIC, 32'd54, 32'd2, 32'd2, 16'd2, 16'd24, 32'd0, 1'b1, 30);
        bmp_case(BMP_MAGIC, 32'd54, 32'd2, 32'd2, 16'd1, 16'd32, 32'd0, 1'b1, 32);
        bmp_case(BMP_MAGIC, 32'd54, 32'd2, 32'd2, 16'd1, 16'd24, 32'd1, 1'b1, 36);
        bmp_case(BMP_MAGIC, 32'd53, 32'd2, 32'd2, 16'd1, 16'd24, 32'd0, 1'b1, 56);
        bmp_case(BMP_MAGIC, 32'd54, 32'd1024, 32'd1, 16'd1, 16'd24, 32'd0, 1'b1, 66);
        bmp_case(BMP_MAGIC, 32'd56, 32'd1, 32'd1024, 16'd1, 16'd24, 32'd0, 1'b1, 64);
        bmp_case(BMP_MAGIC, 32'd58, 32'd3, 32'd2, 16'd1, 16'd24, 32'd0, 1'b1, 0);
        // restart in the middle of a header
        bmp_case(BMP_MAGIC, 32'd54, 32'd2, 32'd2, 16'd1, 16'd24, 32'd0, 1'b1, 20);
        bmp_case(BMP_MAGIC, 32'd54, 32'd2, 32'd2, 16'd1, 16'd24, 32'd0, 1'b1, 0);

        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: load_coeffs('1, '1, '1, 16'h7FFF, 16'h7FFF, 16'h7FFF);
                1: load_coeffs('0, '0, '0, 16'h8000, 16'h8000, 16'h8000);
                default: load_coeffs(18'($urandom_range(0, 262143)),
                                     18'($urandom_range(0, 262143)),
                                     18'($urandom_range(0, 262143)), 16'($urandom),
                                     16'($urandom), 16'($urandom));
            endcase
            if (p == 4)
                calm <= 1'b1;
            target = bytes_sent + 60;
            while (bytes_sent < target)
                random_file();
        end

        settle();
        if (bad_beats == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/bmpn_pkg.sv
rtl/core/bmpn_scale.sv
rtl/core/bmp24_pixel_normalizer.sv
rtl/core/bmpn_checker.sv
tb/bmpn_beat_checker.sv
tb/testbench.sv
